FILE: hw/rtl/gif_lzw_decoder_assert.svh
// assertion macros for the gif lzw decoder
`ifndef GIF_LZW_DECODER_ASSERT_SVH
`define GIF_LZW_DECODER_ASSERT_SVH

// invariant checked at every clock edge outside reset
`define GLD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication checked at every clock edge outside reset
`define GLD_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

FILE: hw/rtl/gld_pkg.sv
`default_nettype none
package gld_pkg;
  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_DEPTH   = 1 << MAX_CODE_BITS;
  localparam int CODE_W        = MAX_CODE_BITS;
  localparam int COUNT_W       = MAX_CODE_BITS + 1;

  // operation codes
  localparam logic [1:0] OP_FEED    = 2'd0;
  localparam logic [1:0] OP_FETCH   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [COUNT_W-1:0] count_t;
endpackage
`default_nettype wire

FILE: hw/rtl/gif_lzw_decoder.sv
`default_nettype none
// GIF LZW raster decoder. Each input word carries an op: feed one code-stream byte (sub-block
// lengths already stripped), fetch one pixel, or restart; every word returns one result word.
// Feed, restart and idle ops are answered from S_IDLE; a fetch served from the expansion
// stack passes S_POPRD and S_POPOUT (stack read is registered). A fetch that decodes a new
// code passes S_DECODE (which answers a clear, end or bad code), then S_WALK and S_WAIT per
// prefix link, a last S_WALK, S_FINISH, S_POPRD and S_POPOUT, one table read per link.
// The block takes one word at a time and stalls its input until the result word is taken.
// min_code_size is applied at reset and restart; the tables keep their contents over a restart.
`include "gif_lzw_decoder_assert.svh"
module gif_lzw_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] op,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            byte_taken,
  output logic            pixel_valid,
  output logic [7:0]      pixel_index,
  output logic            image_done,
  output logic            stream_error
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_POPRD  = 3'd5;
  localparam logic [2:0] S_POPOUT = 3'd6;

  localparam gld_pkg::count_t LIMIT = gld_pkg::count_t'(gld_pkg::TABLE_DEPTH);

  logic [2:0]            state;
  logic [3:0]            min_code_size;
  logic [23:0]           bit_buffer;
  logic [4:0]            bit_count;
  logic [3:0]            code_width;
  gld_pkg::count_t       next_code;
  gld_pkg::count_t       stack_count;
  gld_pkg::count_t       guard;
  gld_pkg::code_t        previous_code;
  logic                  previous_valid;
  logic [7:0]            first_symbol;
  logic                  done_flag;
  logic                  error_flag;
  gld_pkg::code_t        code;
  gld_pkg::code_t        cur;

  // tables and stack
  gld_pkg::code_t        prefix_mem [gld_pkg::TABLE_DEPTH];
  logic [7:0]            suffix_mem [gld_pkg::TABLE_DEPTH];
  logic [7:0]            stack_mem  [gld_pkg::TABLE_DEPTH];
  gld_pkg::code_t        prefix_rd;
  logic [7:0]            suffix_rd;
  logic [7:0]            stack_rd;

  logic [3:0]            eff_min;
  gld_pkg::code_t        clear_code;
  gld_pkg::code_t        code_mask;
  gld_pkg::code_t        new_code;
  logic                  is_kwk;
  logic                  code_bad;
  logic                  stk_we;
  logic [7:0]            stk_wdata;
  logic                  tbl_we;
  logic                  tbl_rd;
  gld_pkg::count_t       next_inc;
  gld_pkg::count_t       stack_dec;

  // clamped code size and derived codes
  always_comb begin
    eff_min = min_code_size;
    if (min_code_size < 4'd2) eff_min = 4'd2;
    if (min_code_size > 4'd8) eff_min = 4'd8;
    clear_code = gld_pkg::code_t'(1) << eff_min;
    code_mask  = gld_pkg::code_t'((13'd1 << code_width) - 13'd1);
    new_code   = bit_buffer[gld_pkg::CODE_W-1:0] & code_mask;
    is_kwk     = {1'b0, code} == next_code;
    code_bad   = ({1'b0, code} > next_code) || (is_kwk && !previous_valid);
    next_inc   = next_code + gld_pkg::count_t'(1);
    stack_dec  = stack_count - gld_pkg::count_t'(1);
  end

  // memory control per state
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = cur[7:0];
    case (state)
      S_DECODE: begin
        stk_we    = (code != clear_code) && (code != clear_code + gld_pkg::code_t'(1)) &&
                    !code_bad && is_kwk && (stack_count < LIMIT);
        stk_wdata = first_symbol;
      end
      S_WAIT: begin
        stk_we    = stack_count < LIMIT;
        stk_wdata = suffix_rd;
      end
      S_FINISH: stk_we = stack_count < LIMIT;
      default: stk_we = 1'b0;
    endcase
    tbl_we = (state == S_FINISH) && previous_valid && (next_code < LIMIT);
    tbl_rd = (state == S_WALK) && (cur >= clear_code) && !guard[gld_pkg::COUNT_W-1];
  end

  // table memories
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      prefix_mem[next_code[gld_pkg::CODE_W-1:0]] <= previous_code;
      suffix_mem[next_code[gld_pkg::CODE_W-1:0]] <= cur[7:0];
    end
    if (tbl_rd) begin
      prefix_rd <= prefix_mem[cur];
      suffix_rd <= suffix_mem[cur];
    end
  end

  // expansion stack memory
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stack_count[gld_pkg::CODE_W-1:0]] <= stk_wdata;
    if (state == S_POPRD) stack_rd <= stack_mem[stack_dec[gld_pkg::CODE_W-1:0]];
  end

  assign in_stall     = (state != S_IDLE) || out_valid;
  assign image_done   = done_flag && (stack_count == '0);
  assign stream_error = error_flag;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      min_code_size  <= 4'd8;
      bit_buffer     <= '0;
      bit_count      <= '0;
      code_width     <= 4'd9;
      next_code      <= gld_pkg::count_t'(258);
      stack_count    <= '0;
      previous_code  <= '0;
      previous_valid <= 1'b0;
      first_symbol   <= '0;
      done_flag      <= 1'b0;
      error_flag     <= 1'b0;
      out_valid      <= 1'b0;
      guard          <= '0;
    end else begin
      if (cfg_we) min_code_size <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (stk_we) stack_count <= stack_count + gld_pkg::count_t'(1);
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            byte_taken  <= 1'b0;
            pixel_valid <= 1'b0;
            pixel_index <= '0;
            case (op)
              gld_pkg::OP_FEED: begin
                out_valid <= 1'b1;
                if (bit_count <= 5'd16) begin
                  bit_buffer <= bit_buffer | (24'(data_byte) << bit_count);
                  bit_count  <= bit_count + 5'd8;
                  byte_taken <= 1'b1;
                end
              end
              gld_pkg::OP_FETCH: begin
                if (stack_count == '0 && !done_flag && bit_count >= 5'(code_width)) begin
                  code       <= new_code;
                  bit_buffer <= bit_buffer >> code_width;
                  bit_count  <= bit_count - 5'(code_width);
                  state      <= S_DECODE;
                end else if (stack_count != '0) begin
                  state     <= S_POPRD;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              gld_pkg::OP_RESTART: begin
                out_valid      <= 1'b1;
                stack_count    <= '0;
                bit_buffer     <= '0;
                bit_count      <= '0;
                previous_code  <= '0;
                first_symbol   <= '0;
                done_flag      <= 1'b0;
                error_flag     <= 1'b0;
                code_width     <= eff_min + 4'd1;
                next_code      <= gld_pkg::count_t'(clear_code) + gld_pkg::count_t'(2);
                previous_valid <= 1'b0;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        // classify the code just taken from the bit buffer
        S_DECODE: begin
          if (code == clear_code) begin
            code_width     <= eff_min + 4'd1;
            next_code      <= gld_pkg::count_t'(clear_code) + gld_pkg::count_t'(2);
            previous_valid <= 1'b0;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end else if (code == clear_code + gld_pkg::code_t'(1)) begin
            done_flag <= 1'b1;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (code_bad) begin
            error_flag <= 1'b1;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            cur   <= is_kwk ? previous_code : code;
            guard <= '0;
            state <= S_WALK;
          end
        end
        // follow the prefix chain one link at a time
        S_WALK: state <= tbl_rd ? S_WAIT : S_FINISH;
        S_WAIT: begin
          cur   <= prefix_rd;
          guard <= guard + gld_pkg::count_t'(1);
          state <= S_WALK;
        end
        // root symbol pushed, new dictionary entry added when a previous code exists and the table has room
        S_FINISH: begin
          first_symbol <= cur[7:0];
          if (tbl_we) begin
            next_code <= next_inc;
            if (next_inc == (gld_pkg::count_t'(1) << code_width) &&
                code_width < 4'(gld_pkg::MAX_CODE_BITS))
              code_width <= code_width + 4'd1;
          end
          previous_code  <= code;
          previous_valid <= 1'b1;
          state          <= S_POPRD;
        end
        S_POPRD: begin
          stack_count <= stack_dec;
          state       <= S_POPOUT;
        end
        S_POPOUT: begin
          pixel_valid <= 1'b1;
          pixel_index <= stack_rd;
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `GLD_ASSERT_IMPLY(a_no_accept_pending, in_valid && !in_stall, !out_valid, "word taken with result pending")
  `GLD_ASSERT_IMPLY(a_one_kind, out_valid, !(byte_taken && pixel_valid), "feed and pixel in one word")
  `GLD_ASSERT_ALWAYS(a_stack_bound, stack_count <= LIMIT, "stack count beyond depth")
  `GLD_ASSERT_ALWAYS(a_next_bound, next_code <= LIMIT, "next code beyond table")
  `GLD_ASSERT_IMPLY(a_pop_nonempty, state == S_POPRD, stack_count != '0, "pop from empty stack")
endmodule
`default_nettype wire

FILE: sim/gif_lzw_decoder_checker.sv
`default_nettype none
module gif_lzw_decoder_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [1:0] op,
  input  wire logic [7:0] data_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic       byte_taken,
  input  wire logic       pixel_valid,
  input  wire logic [7:0] pixel_index,
  input  wire logic       image_done,
  input  wire logic       stream_error,
  output int              mismatches,
  output int              words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       taken;
    logic       pvalid;
    logic [7:0] pix;
    logic       done;
    logic       err;
  } pixel_result_t;

  pixel_result_t expected_words[$];

  // decoder state mirror
  logic [11:0] prefix_mem [gld_pkg::TABLE_DEPTH];
  logic [7:0]  suffix_mem [gld_pkg::TABLE_DEPTH];
  logic [7:0]  pixel_stack [gld_pkg::TABLE_DEPTH];
  int unsigned stack_fill, bit_store, bits_held, width_now, free_code, last_code, first_sym;
  bit          last_ok, eoi_seen, err_seen;
  logic [3:0]  min_size_reg;

  function automatic int unsigned clamped_min();
    if (min_size_reg < 2) return 2;
    if (min_size_reg > 8) return 8;
    return min_size_reg;
  endfunction

  function automatic void clear_dictionary();
    width_now = clamped_min() + 1;
    free_code = (1 << clamped_min()) + 2;
    last_ok   = 1'b0;
  endfunction

  function automatic void restart_decoder();
    stack_fill = 0;
    bit_store  = 0;
    bits_held  = 0;
    last_code  = 0;
    first_sym  = 0;
    eoi_seen   = 1'b0;
    err_seen   = 1'b0;
    clear_dictionary();
  endfunction

  function automatic void push_pixel(int unsigned v);
    if (stack_fill < gld_pkg::TABLE_DEPTH) begin
      pixel_stack[stack_fill] = v[7:0];
      stack_fill++;
    end
  endfunction

  // expand one code onto the stack and grow the dictionary
  function automatic void expand_code(int unsigned c);
    int unsigned clr, walk, hops;
    clr  = 1 << clamped_min();
    hops = 0;
    if (c == clr) begin
      clear_dictionary();
      return;
    end
    if (c == clr + 1) begin
      eoi_seen = 1'b1;
      return;
    end
    if (c > free_code || (c == free_code && !last_ok)) begin
      err_seen = 1'b1;
      return;
    end
    if (c == free_code) begin
      push_pixel(first_sym);
      walk = last_code;
    end else begin
      walk = c;
    end
    while (walk >= clr && hops < gld_pkg::TABLE_DEPTH) begin
      push_pixel(suffix_mem[walk & 12'hFFF]);
      walk = prefix_mem[walk & 12'hFFF];
      hops++;
    end
    push_pixel(walk);
    first_sym = walk & 8'hFF;
    if (last_ok && free_code < gld_pkg::TABLE_DEPTH) begin
      prefix_mem[free_code & 12'hFFF] = last_code[11:0];
      suffix_mem[free_code & 12'hFFF] = first_sym[7:0];
      free_code++;
      if (free_code == (1 << width_now) && width_now < gld_pkg::MAX_CODE_BITS) width_now++;
    end
    last_code = c & 12'hFFF;
    last_ok   = 1'b1;
  endfunction

  function automatic pixel_result_t decode_word(logic [1:0] o, logic [7:0] b);
    pixel_result_t r;
    int unsigned   c;
    r = '0;
    case (o)
      gld_pkg::OP_FEED: begin
        if (bits_held <= 16) begin
          bit_store = (bit_store | ({24'd0, b} << bits_held)) & 24'hFFFFFF;
          bits_held += 8;
          r.taken = 1'b1;
        end
      end
      gld_pkg::OP_FETCH: begin
        if (stack_fill == 0 && !eoi_seen && bits_held >= width_now) begin
          c = bit_store & ((1 << width_now) - 1);
          bit_store >>= width_now;
          bits_held -= width_now;
          expand_code(c);
        end
        if (stack_fill > 0) begin
          stack_fill--;
          r.pix    = pixel_stack[stack_fill];
          r.pvalid = 1'b1;
        end
      end
      gld_pkg::OP_RESTART: restart_decoder();
      default: ;
    endcase
    r.done = eoi_seen && stack_fill == 0;
    r.err  = err_seen;
    return r;
  endfunction

  assign words_pending = expected_words.size();

  // follow config, predict on each input word, compare each output word
  always @(posedge clk) begin
    pixel_result_t got, want;
    if (rst) begin
      min_size_reg = 4'd8;
      restart_decoder();
      expected_words.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) min_size_reg = cfg_data;
      if (in_valid && !in_stall)
        expected_words.insert(expected_words.size(), decode_word(op, data_byte));
      if (out_valid && !out_stall) begin
        got = '{byte_taken, pixel_valid, pixel_index, image_done, stream_error};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output word %p", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: sim/gif_lzw_decoder_tb.sv
`default_nettype none
module gif_lzw_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int IDLE_LIMIT = 40000;
  localparam int RANDOM_WORDS = 1000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_data = 4'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] op = gld_pkg::OP_FEED;
  logic [7:0] data_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       byte_taken, pixel_valid, image_done, stream_error;
  logic [7:0] pixel_index;
  int         mismatches, words_pending;

  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int words_sent = 0;

  // last result word seen by the driver
  logic res_taken, res_pvalid, res_done;

  // stream builder state
  byte unsigned code_bytes[$];
  int unsigned  pack_bits, pack_count;
  int unsigned  s_min, s_width, s_next;
  bit           s_prev;

  gif_lzw_decoder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .byte_taken(byte_taken),
    .pixel_valid(pixel_valid), .pixel_index(pixel_index), .image_done(image_done),
    .stream_error(stream_error)
  );

  gif_lzw_decoder_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .byte_taken(byte_taken),
    .pixel_valid(pixel_valid), .pixel_index(pixel_index), .image_done(image_done),
    .stream_error(stream_error), .mismatches(mismatches), .words_pending(words_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // output side stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && !rst && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on channel activity
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // send one word and wait for its result
  task automatic send_word(logic [1:0] o, logic [7:0] b);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    op = o;
    data_byte = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    do @(posedge clk); while (!(out_valid && !out_stall));
    res_taken = byte_taken;
    res_pvalid = pixel_valid;
    res_done = image_done;
    words_sent++;
  endtask

  task automatic write_min_size(logic [3:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    s_min = (v < 2) ? 2 : (v > 8) ? 8 : v;
    send_word(gld_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
  endtask

  task automatic start_stream();
    code_bytes.delete();
    pack_bits = 0;
    pack_count = 0;
    s_width = s_min + 1;
    s_next = (1 << s_min) + 2;
    s_prev = 1'b0;
  endtask

  // pack one code LSB-first and track the dictionary as the decoder will
  task automatic emit_code(int unsigned c);
    int unsigned clr;
    clr = 1 << s_min;
    pack_bits |= c << pack_count;
    pack_count += s_width;
    while (pack_count >= 8) begin
      code_bytes.insert(code_bytes.size(), 8'(pack_bits));
      pack_bits >>= 8;
      pack_count -= 8;
    end
    if (c == clr) begin
      s_width = s_min + 1;
      s_next = clr + 2;
      s_prev = 1'b0;
    end else if (c != clr + 1 && !(c > s_next || (c == s_next && !s_prev))) begin
      if (s_prev && s_next < gld_pkg::TABLE_DEPTH) begin
        s_next++;
        if (s_next == (1 << s_width) && s_width < gld_pkg::MAX_CODE_BITS) s_width++;
      end
      s_prev = 1'b1;
    end
  endtask

  task automatic end_stream();
    if (pack_count > 0) code_bytes.insert(code_bytes.size(), 8'(pack_bits));
  endtask

  // mostly valid codes, with clears, bad codes and next-code repeats mixed in
  task automatic emit_random_code(bit fill);
    int unsigned clr, code_top, r;
    clr = 1 << s_min;
    code_top = 1 << s_width;
    r = $urandom_range(0, 99);
    if (!fill && r < 3 && s_next + 1 < code_top)
      emit_code($urandom_range(s_next + 1, code_top - 1));
    else if (!fill && r < 6)
      emit_code(clr);
    else if (!s_prev && r < 8)
      emit_code(s_next);
    else if (s_prev && s_next < gld_pkg::TABLE_DEPTH && r < (fill ? 2 : 16))
      emit_code(s_next);
    else if (s_next > clr + 2 && r < (fill ? 10 : 50))
      emit_code($urandom_range(clr + 2, s_next - 1));
    else
      emit_code($urandom_range(0, clr - 1));
  endtask

  // feed the built stream, fetching when the buffer is full; drain pixels if all of it was fed, then restart
  task automatic play_stream(bit may_cut);
    int cut, tries, streak;
    cut = code_bytes.size();
    if (may_cut && $urandom_range(0, 19) == 0) cut = $urandom_range(0, code_bytes.size());
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 5) == 0)
        send_word(gld_pkg::OP_FETCH, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 39) == 0) send_word(OP_NONE, 8'($urandom_range(0, 255)));
      send_word(gld_pkg::OP_FEED, code_bytes[i]);
      tries = 0;
      while (!res_taken && tries < 20) begin
        send_word(gld_pkg::OP_FETCH, 8'($urandom_range(0, 255)));
        send_word(gld_pkg::OP_FEED, code_bytes[i]);
        tries++;
      end
    end
    streak = 0;
    if (cut == code_bytes.size()) begin
      res_done = 1'b0;
      while (!res_done && streak < 12) begin
        send_word(gld_pkg::OP_FETCH, 8'($urandom_range(0, 255)));
        streak = res_pvalid ? 0 : streak + 1;
      end
    end
    send_word(gld_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_image(int n_codes, bit fill);
    start_stream();
    if (fill || $urandom_range(0, 9) < 7) emit_code(1 << s_min);
    repeat (n_codes) emit_random_code(fill);
    if (fill || $urandom_range(0, 19) < 17) emit_code((1 << s_min) + 1);
    end_stream();
    play_stream(!fill);
  endtask

  initial begin
    int           start_words, phase;
    logic [3:0]   cfg_list[4];
    cfg_list = '{4'd2, 4'd8, 4'd0, 4'd15};
    s_min = 8;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: fetch on empty buffer, literals, table code, next-code repeat,
    // bad codes, clear, end of information
    send_word(gld_pkg::OP_FETCH, 8'h00);
    start_stream();
    emit_code(256); emit_code(0); emit_code(255); emit_code(258); emit_code(260);
    emit_code(400); emit_code(256); emit_code(258); emit_code(7); emit_code(257);
    end_stream();
    play_stream(1'b0);
    // buffer full refusal, unused op, restart
    send_word(gld_pkg::OP_FEED, 8'hFF);
    send_word(gld_pkg::OP_FEED, 8'h00);
    send_word(gld_pkg::OP_FEED, 8'hA5);
    send_word(gld_pkg::OP_FEED, 8'h5A);
    send_word(OP_NONE, 8'hC3);
    send_word(gld_pkg::OP_RESTART, 8'h3C);

    // random images across settings
    start_words = words_sent;
    phase = 0;
    while (words_sent - start_words < RANDOM_WORDS) begin
      if (words_sent - start_words > RANDOM_WORDS * 4 / 5) quiet = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        write_min_size(phase < 4 ? cfg_list[phase] : 4'($urandom_range(0, 15)));
        phase++;
      end
      random_image($urandom_range(4, 60), 1'b0);
    end

    while (words_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: gif_lzw_decoder.f
+incdir+hw/rtl
hw/rtl/gld_pkg.sv
hw/rtl/gif_lzw_decoder.sv
sim/gif_lzw_decoder_checker.sv
sim/gif_lzw_decoder_tb.sv
